// ===== rtl/rism_pkg.sv =====
// Shared widths, operand type and a helper function for the run segment moments block.
package rism_pkg;

    // Shared multiplier operand and kept product widths.
    localparam int OP_W   = 25;
    localparam int PROD_W = 41;

    // Result field widths.
    localparam int AREA_W = 21;
    localparam int SUMX_W = 30;
    localparam int SUMY_W = 30;
    localparam int CXX_W  = 40;
    localparam int CXY_W  = 41;
    localparam int CYY_W  = 40;

    // Inverse of three modulo 2^21, used for exact division of a multiple of three.
    localparam int      INV3_W = 21;
    localparam logic [INV3_W-1:0] INV3 = 21'd699051;

    typedef logic signed [OP_W-1:0] t_operand;

    // Residue of an 11-bit value modulo three: base-4 digits sum, then fold.
    function automatic logic [1:0] mod3_11(input logic [10:0] v);
        logic [4:0] s;
        s = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8]) + 5'(v[10]);
        if (s >= 5'd12) begin
            s = s - 5'd12;
        end
        if (s >= 5'd6) begin
            s = s - 5'd6;
        end
        if (s >= 5'd3) begin
            s = s - 5'd3;
        end
        return s[1:0];
    endfunction

endpackage

// ===== rtl/rism_mul.sv =====
// Shared signed multiplier with a registered product.
module rism_mul
    import rism_pkg::*;
(
    input  logic              i_clk,
    input  t_operand          i_a,
    input  t_operand          i_b,
    output logic [PROD_W-1:0] o_prod
);

    logic signed [2*OP_W-1:0] prod_full;
    logic [PROD_W-1:0]        r_prod;

    // Full signed product; only the low bits feed the modular accumulators.
    assign prod_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= prod_full[PROD_W-1:0];
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/run_segment_image_moments_unit.sv =====
// Top level: sequencer, accumulators and output register for blob moments from run segments.
// Each segment passes through an idle step that takes the word, then eleven steps in which
// one shared multiplier does ten products in turn; the multiplier sets the rate.
// A new segment is taken only after the previous one's final step; a final segment's result
// word is registered from its final step, which waits while the previous word is not taken.
// Reset (synchronous, active low) clears the sequencer, the accumulators and the output valid.
module run_segment_image_moments_unit
    import rism_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // seg_x[9:0], seg_y[19:10], run_length[30:20], center_x[40:31], center_y[50:41], zero pad
    input  logic [55:0]  i_s_tdata,
    // last_segment
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // area[20:0], sum_x[50:21], sum_y[80:51], central_xx[120:81], central_xy[161:121],
    // central_yy[201:162], zero pad
    output logic [207:0] o_m_tdata
);

    // Sequencer steps.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_P    = 4'd1;
    localparam logic [3:0] S_XN   = 4'd2;
    localparam logic [3:0] S_Q    = 4'd3;
    localparam logic [3:0] S_NY   = 4'd4;
    localparam logic [3:0] S_H    = 4'd5;
    localparam logic [3:0] S_NA   = 4'd6;
    localparam logic [3:0] S_DX2  = 4'd7;
    localparam logic [3:0] S_ANAP = 4'd8;
    localparam logic [3:0] S_NDX2 = 4'd9;
    localparam logic [3:0] S_XY   = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0]        r_state;
    logic [3:0]        n_state;

    // Captured segment.
    logic [9:0]        r_x;
    logic [9:0]        r_y0;
    logic [10:0]       r_n;
    logic [9:0]        r_cx;
    logic [9:0]        r_cy;
    logic              r_last;

    // Intermediate results.
    logic [20:0]       r_g;
    logic [20:0]       r_q;
    t_operand          r_sdy;
    t_operand          r_nap;
    logic [19:0]       r_dx2;

    // Accumulators.
    logic [AREA_W-1:0] r_acc_area;
    logic [SUMX_W-1:0] r_acc_sum_x;
    logic [SUMY_W-1:0] r_acc_sum_y;
    logic [CXX_W-1:0]  r_acc_cxx;
    logic [CXY_W-1:0]  r_acc_cxy;
    logic [CYY_W-1:0]  r_acc_cyy;
    logic [CXY_W-1:0]  n_acc_cxy;

    // Output register.
    logic              r_out_valid;
    logic [201:0]      r_out_data;

    t_operand          mul_a;
    t_operand          mul_b;
    logic [PROD_W-1:0] prod;

    logic signed [10:0] a_dif;
    logic signed [10:0] dx;
    logic [10:0]        n_m1;
    logic [11:0]        two_n_m1;
    logic               r2;
    logic [20:0]        d_op;
    logic [20:0]        e_op;
    logic               in_fire;
    logic               done_go;

    rism_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Offsets from the centre and the factors of the closed-form row sums.
    assign a_dif    = 11'($signed({1'b0, r_y0}) - $signed({1'b0, r_cy}));
    assign dx       = 11'($signed({1'b0, r_x}) - $signed({1'b0, r_cx}));
    assign n_m1     = r_n - 11'd1;
    assign two_n_m1 = {r_n, 1'b0} - 12'd1;

    // The factor that three divides: 2n-1 when n is two modulo three, else n(n-1)/2.
    assign r2   = (mod3_11(r_n) == 2'd2);
    assign d_op = r2 ? 21'(two_n_m1) : r_g;
    assign e_op = r2 ? r_g : 21'(two_n_m1);

    assign in_fire    = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign done_go    = !r_last || !r_out_valid || i_m_tready;
    assign n_acc_cxy  = r_acc_cxy + prod[CXY_W-1:0];

    // Operand selection for the shared multiplier; the last product is held through the
    // final step so that it is still there when that step waits.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_P: begin
                mul_a = OP_W'(r_n);
                mul_b = OP_W'(n_m1);
            end
            S_XN: begin
                mul_a = OP_W'(r_x);
                mul_b = OP_W'(r_n);
            end
            S_Q: begin
                mul_a = OP_W'(d_op);
                mul_b = OP_W'(INV3);
            end
            S_NY: begin
                mul_a = OP_W'(r_n);
                mul_b = OP_W'(r_y0);
            end
            S_H: begin
                mul_a = OP_W'(r_q);
                mul_b = OP_W'(e_op);
            end
            S_NA: begin
                mul_a = OP_W'(r_n);
                mul_b = OP_W'(a_dif);
            end
            S_DX2: begin
                mul_a = OP_W'(dx);
                mul_b = OP_W'(dx);
            end
            S_ANAP: begin
                mul_a = OP_W'(a_dif);
                mul_b = r_nap;
            end
            S_NDX2: begin
                mul_a = OP_W'(r_n);
                mul_b = OP_W'(r_dx2);
            end
            S_XY, S_DONE: begin
                mul_a = OP_W'(dx);
                mul_b = r_sdy;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Next step of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_P;
                end
            end
            S_DONE: begin
                if (done_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = r_state + 4'd1;
            end
        endcase
    end

    // Control state and accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_acc_area  <= '0;
            r_acc_sum_x <= '0;
            r_acc_sum_y <= '0;
            r_acc_cxx   <= '0;
            r_acc_cxy   <= '0;
            r_acc_cyy   <= '0;
        end else begin
            r_state <= n_state;
            // A new result word replaces the old one, else a taken word is dropped.
            if (r_state == S_DONE && done_go && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_P: begin
                    r_acc_area <= r_acc_area + AREA_W'(r_n);
                end
                S_Q: begin
                    r_acc_sum_x <= r_acc_sum_x + prod[SUMX_W-1:0];
                end
                S_H: begin
                    r_acc_sum_y <= r_acc_sum_y + prod[SUMY_W-1:0] + SUMY_W'(r_g);
                end
                S_NA: begin
                    r_acc_cyy <= r_acc_cyy + prod[CYY_W-1:0];
                end
                S_NDX2: begin
                    r_acc_cyy <= r_acc_cyy + prod[CYY_W-1:0];
                end
                S_XY: begin
                    r_acc_cxx <= r_acc_cxx + prod[CXX_W-1:0];
                end
                S_DONE: begin
                    if (done_go) begin
                        if (r_last) begin
                            r_acc_area  <= '0;
                            r_acc_sum_x <= '0;
                            r_acc_sum_y <= '0;
                            r_acc_cxx   <= '0;
                            r_acc_cxy   <= '0;
                            r_acc_cyy   <= '0;
                        end else begin
                            r_acc_cxy <= n_acc_cxy;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Segment capture, intermediate results and the result word.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x    <= i_s_tdata[9:0];
            r_y0   <= i_s_tdata[19:10];
            r_n    <= i_s_tdata[30:20];
            r_cx   <= i_s_tdata[40:31];
            r_cy   <= i_s_tdata[50:41];
            r_last <= i_s_tlast;
        end
        case (r_state)
            S_XN: begin
                r_g <= prod[21:1];
            end
            S_NY: begin
                r_q <= prod[20:0];
            end
            S_DX2: begin
                r_sdy <= prod[OP_W-1:0] + OP_W'(r_g);
                r_nap <= prod[OP_W-1:0] + OP_W'({r_g, 1'b0});
            end
            S_ANAP: begin
                r_dx2 <= prod[19:0];
            end
            S_DONE: begin
                if (done_go && r_last) begin
                    r_out_data <= {r_acc_cyy, n_acc_cxy, r_acc_cxx,
                                   r_acc_sum_y, r_acc_sum_x, r_acc_area};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_data};

`ifndef SYNTHESIS
    // A taken segment keeps the block busy in the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_s_tready)
        else $error("segment taken while the previous one was still in work");

    // A result word only appears from the final step of a final segment.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == S_DONE) && $past(r_last))
        else $error("result word raised outside the final step");

    // The final step of a final segment holds while the previous result word waits.
    a_final_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_last && o_m_tvalid && !i_m_tready) |=>
        (r_state == S_DONE) && $stable(r_acc_cxy))
        else $error("final step advanced over an untaken result word");

    // Accumulators restart from zero once a result word is formed.
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> (r_acc_area == '0) && (r_acc_cyy == '0))
        else $error("accumulators not cleared after a result word");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the run segment image moments block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rism_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RUN_TARGET  = 1900;
    localparam int LONG_BLOB   = 1100;

    // One vertical run segment as carried by an input word.
    typedef struct {
        logic [9:0]  seg_x;
        logic [9:0]  seg_y;
        logic [10:0] run_length;
        logic [9:0]  center_x;
        logic [9:0]  center_y;
        logic        last_segment;
    } segment_t;

    // Moment totals of one blob as carried by a result word.
    typedef struct {
        logic [AREA_W-1:0] area;
        logic [SUMX_W-1:0] sum_x;
        logic [SUMY_W-1:0] sum_y;
        logic [CXX_W-1:0]  central_xx;
        logic [CXY_W-1:0]  central_xy;
        logic [CYY_W-1:0]  central_yy;
    } moments_t;

    // A row of the directed table; known rows carry their totals typed in.
    typedef struct {
        segment_t seg;
        bit       known;
        moments_t want;
    } table_row_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    // seg_x[9:0], seg_y[19:10], run_length[30:20], center_x[40:31], center_y[50:41], zero pad
    logic [55:0]  i_s_tdata;
    // last_segment
    logic         i_s_tlast;
    logic         o_m_tvalid;
    logic         i_m_tready;
    // area[20:0], sum_x[50:21], sum_y[80:51], central_xx[120:81], central_xy[161:121],
    // central_yy[201:162], zero pad
    logic [207:0] o_m_tdata;

    moments_t   blob_totals = '{default: '0};
    moments_t   pending_moments[$];
    table_row_t directed_rows[$];
    int         mismatches = 0;
    int         cycle_count = 0;
    int         runs_sent = 0;
    int         burst_left = 0;
    logic [9:0] stall_phase = '0;

    run_segment_image_moments_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the total run time.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    // Sum of k for k = 0 .. n-1.
    function automatic bit [63:0] tri_rows(input bit [63:0] n);
        return (n == 0) ? 64'd0 : (n * (n - 64'd1)) / 64'd2;
    endfunction

    // Sum of k*k for k = 0 .. n-1.
    function automatic bit [63:0] sq_rows(input bit [63:0] n);
        return (n == 0) ? 64'd0 : (n * (n - 64'd1) * (64'd2 * n - 64'd1)) / 64'd6;
    endfunction

    // Adds one run to the blob totals; on the final run hands them out and clears them.
    // All products are taken modulo 2^64 and then cut to the field widths.
    task automatic accumulate_run(input segment_t s, output bit emitted,
                                  output moments_t totals);
        bit [63:0] x, y0, n, cx, cy, y1, sy, syy, dx;
        x   = 64'(s.seg_x);
        y0  = 64'(s.seg_y);
        n   = 64'(s.run_length);
        cx  = 64'(s.center_x);
        cy  = 64'(s.center_y);
        y1  = y0 + n;
        sy  = tri_rows(y1) - tri_rows(y0);
        syy = sq_rows(y1) - sq_rows(y0);
        dx  = x - cx;
        blob_totals.area       = AREA_W'(64'(blob_totals.area) + n);
        blob_totals.sum_x      = SUMX_W'(64'(blob_totals.sum_x) + x * n);
        blob_totals.sum_y      = SUMY_W'(64'(blob_totals.sum_y) + sy);
        blob_totals.central_xx = CXX_W'(64'(blob_totals.central_xx) + n * dx * dx);
        blob_totals.central_xy = CXY_W'(64'(blob_totals.central_xy) + dx * (sy - n * cy));
        blob_totals.central_yy = CYY_W'(64'(blob_totals.central_yy) + syy
                                        - 64'd2 * cy * sy + n * cy * cy);
        emitted = s.last_segment;
        totals  = blob_totals;
        if (emitted) begin
            blob_totals = '{default: '0};
        end
    endtask

    // Drives one segment word in bursts with random gaps and waits for it to be taken.
    task automatic send_segment(input segment_t s, input bit known, input moments_t want);
        int       gap;
        bit       emitted;
        moments_t totals;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, s.center_y, s.center_x, s.run_length, s.seg_y, s.seg_x};
        i_s_tlast  <= s.last_segment;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        runs_sent++;
        accumulate_run(s, emitted, totals);
        if (known) begin
            pending_moments = {pending_moments, want};
        end else if (emitted) begin
            pending_moments = {pending_moments, totals};
        end
    endtask

    task automatic row_checked(input int x, input int y, input int n, input int cx,
                               input int cy, input bit last);
        table_row_t r;
        r.seg   = '{10'(x), 10'(y), 11'(n), 10'(cx), 10'(cy), last};
        r.known = 1'b0;
        r.want  = '{default: '0};
        directed_rows = {directed_rows, r};
    endtask

    // A single-run blob whose totals are written out by hand.
    task automatic row_known(input int x, input int y, input int n, input int cx,
                             input int cy, input longint area, input longint sx,
                             input longint sy, input longint cxx, input longint cxy,
                             input longint cyy);
        table_row_t r;
        r.seg   = '{10'(x), 10'(y), 11'(n), 10'(cx), 10'(cy), 1'b1};
        r.known = 1'b1;
        r.want  = '{AREA_W'(area), SUMX_W'(sx), SUMY_W'(sy), CXX_W'(cxx), CXY_W'(cxy),
                    CYY_W'(cyy)};
        directed_rows = {directed_rows, r};
    endtask

    // A blob of random runs; a noisy blob takes every field over its full range.
    task automatic send_random_blob(input int nseg, input bit noisy);
        segment_t s;
        moments_t none;
        int       cx, cy;
        none = '{default: '0};
        cx = $urandom_range(0, 1023);
        cy = $urandom_range(0, 1023);
        for (int k = 0; k < nseg; k++) begin
            s.center_x = 10'(cx);
            s.center_y = 10'(cy);
            // Now and then a run carries a centre of its own.
            if (noisy || $urandom_range(0, 7) == 0) begin
                s.center_x = 10'($urandom_range(0, 1023));
                s.center_y = 10'($urandom_range(0, 1023));
            end
            s.seg_y = 10'($urandom_range(0, 1023));
            if (noisy) begin
                s.seg_x      = 10'($urandom_range(0, 1023));
                s.run_length = 11'($urandom_range(0, 2047));
            end else begin
                s.seg_x = 10'(cx + $urandom_range(0, 40) - 20);
                case ($urandom_range(0, 15))
                    0:       s.run_length = 11'd0;
                    1:       s.run_length = 11'($urandom_range(1024, 2047));
                    2:       s.run_length = 11'd1;
                    default: s.run_length = 11'($urandom_range(1, 80));
                endcase
            end
            s.last_segment = (k == nseg - 1);
            send_segment(s, 1'b0, none);
        end
    endtask

    // Result side stalls on a pattern that cycles through four modes.
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 10'd1;
        case (stall_phase[9:8])
            2'd0: begin
                i_m_tready <= 1'b1;
            end
            2'd1: begin
                i_m_tready <= ($urandom_range(0, 1) == 1);
            end
            2'd2: begin
                i_m_tready <= (stall_phase[3:0] < 4'd5);
            end
            default: begin
                i_m_tready <= (stall_phase[5:0] == 6'd0);
            end
        endcase
    end

    // Compare every result word taken with the oldest pending blob.
    always @(posedge i_clk) begin
        moments_t got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.area       = o_m_tdata[20:0];
            got.sum_x      = o_m_tdata[50:21];
            got.sum_y      = o_m_tdata[80:51];
            got.central_xx = o_m_tdata[120:81];
            got.central_xy = o_m_tdata[161:121];
            got.central_yy = o_m_tdata[201:162];
            if (pending_moments.size() == 0) begin
                report_mismatch("result word with no blob pending");
            end else begin
                want = pending_moments.pop_front();
                check_field("area", 64'(got.area), 64'(want.area));
                check_field("sum_x", 64'(got.sum_x), 64'(want.sum_x));
                check_field("sum_y", 64'(got.sum_y), 64'(want.sum_y));
                check_field("central_xx", 64'(got.central_xx), 64'(want.central_xx));
                check_field("central_xy", 64'(got.central_xy), 64'(want.central_xy));
                check_field("central_yy", 64'(got.central_yy), 64'(want.central_yy));
            end
        end
    end

    initial begin
        segment_t s;
        moments_t none;
        bit       long_done;
        int       blob_len;
        none       = '{default: '0};
        long_done  = 1'b0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single-run blobs at the extremes, totals written out.
        row_known(0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0);
        row_known(0, 0, 0, 1023, 1023, 0, 0, 0, 0, 0, 0);
        row_known(1023, 0, 1, 0, 0, 1, 1023, 0, 1046529, 0, 0);
        row_known(0, 1023, 1, 0, 0, 1, 0, 1023, 0, 0, 1046529);
        row_known(0, 0, 1, 1023, 1023, 1, 0, 0, 1046529, 1046529, 1046529);
        row_known(1023, 0, 1, 0, 1023, 1, 1023, 0, 1046529, -1046529, 1046529);
        // Longest run, past the image edge, then from the top.
        row_checked(1023, 1023, 2047, 512, 512, 0);
        row_checked(0, 0, 2047, 512, 512, 1);
        // Several runs with an empty one in the middle.
        row_checked(10, 20, 5, 12, 22, 0);
        row_checked(11, 18, 0, 12, 22, 0);
        row_checked(12, 19, 7, 12, 22, 0);
        row_checked(13, 21, 3, 12, 22, 1);
        // Centre moves between runs of the same blob.
        row_checked(100, 200, 30, 105, 210, 0);
        row_checked(101, 199, 31, 90, 180, 1);
        // A blob made only of empty runs.
        row_checked(5, 5, 0, 5, 5, 0);
        row_checked(5, 5, 0, 5, 5, 1);
        // Lengths with the top bits set.
        row_checked(512, 0, 1024, 0, 1023, 1);
        row_checked(0, 0, 2047, 1023, 0, 1);
        row_checked(341, 682, 1365, 682, 341, 1);
        foreach (directed_rows[i]) begin
            send_segment(directed_rows[i].seg, directed_rows[i].known,
                         directed_rows[i].want);
        end

        // Random blobs, with one very long blob that wraps the area and sum_y accumulators.
        while (runs_sent < RUN_TARGET) begin
            if (!long_done && runs_sent >= 400) begin
                long_done    = 1'b1;
                s.center_x   = 10'($urandom_range(0, 1023));
                s.center_y   = 10'($urandom_range(0, 1023));
                for (int k = 0; k < LONG_BLOB; k++) begin
                    s.seg_x        = 10'($urandom_range(0, 1023));
                    s.seg_y        = 10'($urandom_range(0, 1023));
                    s.run_length   = 11'($urandom_range(2000, 2047));
                    s.last_segment = (k == LONG_BLOB - 1);
                    send_segment(s, 1'b0, none);
                end
            end else begin
                blob_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 12);
                send_random_blob(blob_len, $urandom_range(0, 5) == 0);
            end
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        // Drain, then give a stray word time to show up.
        while (pending_moments.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
